// File: design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion unit.
// No dependencies; used by the top level.
package rmq_pkg;

  // Port widths of matrix entries and quaternion components
  localparam int IN_W   = 16;
  localparam int QW_W   = 15;
  localparam int QXYZ_W = 16;

  // Side-band that travels alongside the square-root pipeline
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } rmq_tag_t;

endpackage

// File: design/rmq_sqrt_pipe.sv
// Pipelined integer square root, one root bit resolved per register stage.
// Standalone; instantiated by rotation_matrix_to_quaternion_unit.
module rmq_sqrt_pipe #(
  parameter int ROOT_W = 16
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [0:ROOT_W];
  logic [REM_W-1:0]  rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] root_q [0:ROOT_W];

  // Stage zero takes the radicand with an empty remainder and root
  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // Bring down two radicand bits and test the next root bit
    assign rem_sh = {rem_q[k][REM_W-3:0], rad_q[k][RAD_W-1:RAD_W-2]};
    assign trial  = {root_q[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    // Advance remainder, root and radicand one stage
    always_ff @(posedge clk) begin
      rem_q[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
      rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
    end
  end

  assign root = root_q[ROOT_W];

endmodule

// File: design/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion, copysign form, fully pipelined.
// Each accepted matrix passes from start to done through one input stage,
// one square-root stage per root bit, and one output stage.
// Throughput: one matrix per cycle; busy is high only during reset and the cycle after.
// Reset (rst, synchronous) clears the in-flight valid bits; results cannot stall.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rmq_pkg::IN_W-1:0] r00,
  input  logic signed [rmq_pkg::IN_W-1:0] r01,
  input  logic signed [rmq_pkg::IN_W-1:0] r02,
  input  logic signed [rmq_pkg::IN_W-1:0] r10,
  input  logic signed [rmq_pkg::IN_W-1:0] r11,
  input  logic signed [rmq_pkg::IN_W-1:0] r12,
  input  logic signed [rmq_pkg::IN_W-1:0] r20,
  input  logic signed [rmq_pkg::IN_W-1:0] r21,
  input  logic signed [rmq_pkg::IN_W-1:0] r22,
  output logic                            done,
  output logic [rmq_pkg::QW_W-1:0]        quat_w,
  output logic signed [rmq_pkg::QXYZ_W-1:0] quat_x,
  output logic signed [rmq_pkg::QXYZ_W-1:0] quat_y,
  output logic signed [rmq_pkg::QXYZ_W-1:0] quat_z
);

  localparam int IN_W   = rmq_pkg::IN_W;
  localparam int SUM_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int MAG_W  = SUM_W - 1;
  localparam int ROOT_W = (MAG_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int EXT_W  = (ROOT_W > rmq_pkg::QXYZ_W) ? ROOT_W : rmq_pkg::QXYZ_W;
  localparam int LAT    = ROOT_W + 2;

  localparam logic signed [SUM_W-1:0] ONE_SUM = {{(SUM_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [EXT_W-1:0]        ONE_EXT = {{(EXT_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Halve the root and clamp at 1.0
  function automatic logic [EXT_W-1:0] half_sat(input logic [ROOT_W-1:0] rt);
    logic [EXT_W-1:0] h;
    h = EXT_W'(rt >> 1);
    if (h > ONE_EXT) begin
      h = ONE_EXT;
    end
    return h;
  endfunction

  // Clamp a signed sum at zero and scale it into a radicand
  function automatic logic [RAD_W-1:0] to_rad(input logic signed [SUM_W-1:0] s);
    logic [RAD_W-1:0] r;
    if (s <= 0) begin
      r = '0;
    end else begin
      r = RAD_W'({s[MAG_W-1:0], {FRAC_BITS{1'b0}}});
    end
    return r;
  endfunction

  logic                      accept;
  logic signed [SUM_W-1:0]   e00, e11, e22;
  logic signed [SUM_W-1:0]   sum_w, sum_x, sum_y, sum_z;
  logic [RAD_W-1:0]          rad_w, rad_x, rad_y, rad_z;
  logic [ROOT_W-1:0]         root_w, root_x, root_y, root_z;
  logic [EXT_W-1:0]          mag_w, mag_x, mag_y, mag_z;
  rmq_pkg::rmq_tag_t         tag_in;
  rmq_pkg::rmq_tag_t         tag_q [0:ROOT_W];

  assign accept = start && !busy;

  // Hold busy for one cycle out of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Form the four diagonal combinations
  assign e00   = {{(SUM_W-IN_W){r00[IN_W-1]}}, r00};
  assign e11   = {{(SUM_W-IN_W){r11[IN_W-1]}}, r11};
  assign e22   = {{(SUM_W-IN_W){r22[IN_W-1]}}, r22};
  assign sum_w = ONE_SUM + e00 + e11 + e22;
  assign sum_x = ONE_SUM + e00 - e11 - e22;
  assign sum_y = ONE_SUM - e00 + e11 - e22;
  assign sum_z = ONE_SUM - e00 - e11 + e22;

  assign tag_in.valid = accept;
  assign tag_in.neg_x = (r21 < r12);
  assign tag_in.neg_y = (r02 < r20);
  assign tag_in.neg_z = (r10 < r01);

  // Register the clamped radicands
  always_ff @(posedge clk) begin
    rad_w <= to_rad(sum_w);
    rad_x <= to_rad(sum_x);
    rad_y <= to_rad(sum_y);
    rad_z <= to_rad(sum_z);
  end

  // Advance valid and sign bits alongside the root stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ROOT_W; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_in;
      for (int i = 1; i <= ROOT_W; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_w (.clk(clk), .rad(rad_w), .root(root_w));
  rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_x (.clk(clk), .rad(rad_x), .root(root_x));
  rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_y (.clk(clk), .rad(rad_y), .root(root_y));
  rmq_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_z (.clk(clk), .rad(rad_z), .root(root_z));

  assign mag_w = half_sat(root_w);
  assign mag_x = half_sat(root_x);
  assign mag_y = half_sat(root_y);
  assign mag_z = half_sat(root_z);

  // Drop the strobe on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_q[ROOT_W].valid;
    end
  end

  // Apply signs and register the result transfer
  always_ff @(posedge clk) begin
    quat_w <= mag_w[rmq_pkg::QW_W-1:0];
    quat_x <= tag_q[ROOT_W].neg_x ? -mag_x[rmq_pkg::QXYZ_W-1:0] : mag_x[rmq_pkg::QXYZ_W-1:0];
    quat_y <= tag_q[ROOT_W].neg_y ? -mag_y[rmq_pkg::QXYZ_W-1:0] : mag_y[rmq_pkg::QXYZ_W-1:0];
    quat_z <= tag_q[ROOT_W].neg_z ? -mag_z[rmq_pkg::QXYZ_W-1:0] : mag_z[rmq_pkg::QXYZ_W-1:0];
  end

  // Every accepted matrix yields exactly one result after the pipeline latency
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted matrix produced no result");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without matching transfer");

  a_busy_reset: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("busy or done wrong after reset");

endmodule

// File: sim/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotation_matrix_to_quaternion_unit.
// Depends on rmq_pkg and the unit; predicts every quaternion from the matrix entries.
module tb_rotation_matrix_to_quaternion_unit;

  localparam int IN_W      = rmq_pkg::IN_W;
  localparam int QW_W      = rmq_pkg::QW_W;
  localparam int QXYZ_W    = rmq_pkg::QXYZ_W;
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  // square-root pipeline depth plus input and output stages
  localparam int LATENCY   = 18;

  typedef logic [8:0][IN_W-1:0] matrix_t;  // row-major, entry row*3+col

  typedef struct {
    logic [QW_W-1:0]   w;
    logic [QXYZ_W-1:0] x;
    logic [QXYZ_W-1:0] y;
    logic [QXYZ_W-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic done;
  logic [QW_W-1:0] quat_w;
  logic signed [QXYZ_W-1:0] quat_x, quat_y, quat_z;

  quat_t pending_quats[$];
  quat_t want_quat;
  int    matrices_sent = 0;
  int    quats_checked = 0;
  int    mismatches    = 0;
  int    unexpected    = 0;
  bit    idle_on       = 1'b1;

  rotation_matrix_to_quaternion_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .r00   (r00),
    .r01   (r01),
    .r02   (r02),
    .r10   (r10),
    .r11   (r11),
    .r12   (r12),
    .r20   (r20),
    .r21   (r21),
    .r22   (r22),
    .done  (done),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Halved integer square root of a clamped Q.14 sum, saturated at 1.0
  function automatic int half_root(longint sum);
    longint unsigned scaled;
    longint unsigned root;
    longint unsigned trial;
    if (sum <= 0) return 0;
    scaled = longint'(sum) << FRAC_BITS;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    root = root >> 1;
    if (root > ONE) root = ONE;
    return int'(root);
  endfunction

  // Copy the sign of an off-diagonal difference; zero stays positive
  function automatic logic [QXYZ_W-1:0] with_sign(int mag, longint diff);
    logic [QXYZ_W-1:0] part;
    part = mag[QXYZ_W-1:0];
    if (diff < 0) part = -part;
    return part;
  endfunction

  function automatic quat_t predict_quaternion(matrix_t m);
    longint d0, d1, d2;
    longint o01, o02, o10, o12, o20, o21;
    quat_t  q;
    int     mw;
    d0  = $signed(m[0]);
    d1  = $signed(m[4]);
    d2  = $signed(m[8]);
    o01 = $signed(m[1]);
    o02 = $signed(m[2]);
    o10 = $signed(m[3]);
    o12 = $signed(m[5]);
    o20 = $signed(m[6]);
    o21 = $signed(m[7]);
    mw  = half_root(ONE + d0 + d1 + d2);
    q.w = mw[QW_W-1:0];
    q.x = with_sign(half_root(ONE + d0 - d1 - d2), o21 - o12);
    q.y = with_sign(half_root(ONE - d0 + d1 - d2), o02 - o20);
    q.z = with_sign(half_root(ONE - d0 - d1 + d2), o10 - o01);
    return q;
  endfunction

  function automatic matrix_t matrix_of(int e00, int e01, int e02, int e10, int e11,
                                        int e12, int e20, int e21, int e22);
    matrix_t m;
    m[0] = e00[IN_W-1:0];
    m[1] = e01[IN_W-1:0];
    m[2] = e02[IN_W-1:0];
    m[3] = e10[IN_W-1:0];
    m[4] = e11[IN_W-1:0];
    m[5] = e12[IN_W-1:0];
    m[6] = e20[IN_W-1:0];
    m[7] = e21[IN_W-1:0];
    m[8] = e22[IN_W-1:0];
    return m;
  endfunction

  // Rotation built from a random quaternion, some parts forced to zero,
  // optionally jittered by a few LSBs so sums straddle zero and one
  function automatic matrix_t rotation_matrix(bit jitter);
    real     qw, qx, qy, qz, n, scaled;
    real     v[9];
    int      e;
    matrix_t m;
    qw = real'(int'($urandom_range(0, 2000)) - 1000);
    qx = real'(int'($urandom_range(0, 2000)) - 1000);
    qy = real'(int'($urandom_range(0, 2000)) - 1000);
    qz = real'(int'($urandom_range(0, 2000)) - 1000);
    if ($urandom_range(0, 3) == 0) qw = 0.0;
    if ($urandom_range(0, 3) == 0) qx = 0.0;
    if ($urandom_range(0, 3) == 0) qy = 0.0;
    if ($urandom_range(0, 3) == 0) qz = 0.0;
    n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (n == 0.0) begin
      qw = 1.0;
      n  = 1.0;
    end
    qw = qw / n;
    qx = qx / n;
    qy = qy / n;
    qz = qz / n;
    v[0] = 1.0 - 2.0 * (qy * qy + qz * qz);
    v[1] = 2.0 * (qx * qy - qz * qw);
    v[2] = 2.0 * (qx * qz + qy * qw);
    v[3] = 2.0 * (qx * qy + qz * qw);
    v[4] = 1.0 - 2.0 * (qx * qx + qz * qz);
    v[5] = 2.0 * (qy * qz - qx * qw);
    v[6] = 2.0 * (qx * qz - qy * qw);
    v[7] = 2.0 * (qy * qz + qx * qw);
    v[8] = 1.0 - 2.0 * (qx * qx + qy * qy);
    for (int i = 0; i < 9; i++) begin
      scaled = v[i] * ONE;
      e = $rtoi(scaled >= 0.0 ? scaled + 0.5 : scaled - 0.5);
      if (jitter) e = e + int'($urandom_range(0, 8)) - 4;
      m[i] = e[IN_W-1:0];
    end
    return m;
  endfunction

  // Entries drawn from the corners of the Q1.14 range, some fully random
  function automatic matrix_t corner_matrix();
    logic [IN_W-1:0] picks[8];
    logic [31:0]     raw;
    matrix_t         m;
    picks = '{16'h8000, 16'hC000, 16'hFFFF, 16'h0000,
              16'h0001, 16'h3FFF, 16'h4000, 16'h7FFF};
    for (int i = 0; i < 9; i++) begin
      raw = $urandom;
      m[i] = ($urandom_range(0, 3) == 0) ? raw[IN_W-1:0] : picks[$urandom_range(0, 7)];
    end
    return m;
  endfunction

  function automatic matrix_t noise_matrix();
    logic [31:0] raw;
    matrix_t     m;
    for (int i = 0; i < 9; i++) begin
      raw = $urandom;
      m[i] = raw[IN_W-1:0];
    end
    return m;
  endfunction

  // Present one matrix at the falling edge, hold it until the transfer
  task automatic send_matrix(input matrix_t m);
    r00   = m[0];
    r01   = m[1];
    r02   = m[2];
    r10   = m[3];
    r11   = m[4];
    r12   = m[5];
    r20   = m[6];
    r21   = m[7];
    r22   = m[8];
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_quats.push_back(predict_quaternion(m));
    matrices_sent++;
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Insert an idle burst now and then while idling is enabled
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
  endtask

  // Drop start and wait until every predicted quaternion has been seen
  task automatic wait_drained();
    start = 1'b0;
    while (pending_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: quaternion with no matrix outstanding", $realtime);
        mismatches++;
        unexpected++;
      end else begin
        want_quat = pending_quats.pop_front();
        compare_field("quat_w", {1'b0, want_quat.w}, {1'b0, quat_w});
        compare_field("quat_x", want_quat.x, quat_x);
        compare_field("quat_y", want_quat.y, quat_y);
        compare_field("quat_z", want_quat.z, quat_z);
        quats_checked++;
      end
    end
  end

  // Range extremes and bit patterns on every entry
  task automatic test_directed_extremes();
    send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(matrix_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(matrix_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768));
    send_matrix(matrix_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    // largest positive and negative off-diagonal differences
    send_matrix(matrix_of(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
    send_matrix(matrix_of(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
    send_matrix(matrix_of('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
                          'h5555));
    send_matrix(matrix_of('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555,
                          'hAAAA));
    wait_drained();
  endtask

  // Half turns, quarter turns, clamps and saturation
  task automatic test_special_cases();
    // half turns: diagonal only, so every difference is zero and signs stay positive
    send_matrix(matrix_of(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send_matrix(matrix_of(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    send_matrix(matrix_of(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    // quarter turns both ways about each axis
    send_matrix(matrix_of(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    send_matrix(matrix_of(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0));
    send_matrix(matrix_of(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0));
    send_matrix(matrix_of(0, 0, -ONE, 0, ONE, 0, ONE, 0, 0));
    send_matrix(matrix_of(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(matrix_of(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE));
    // w sum exactly zero, then one LSB, then one LSB below zero
    send_matrix(matrix_of(-ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(matrix_of(-ONE + 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(matrix_of(-ONE - 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // non-rotation input that saturates w, and one that clamps x, y and z
    send_matrix(matrix_of(32767, 5, -5, 7, 32767, -7, 9, -9, 32767));
    send_matrix(matrix_of(ONE, 3, 3, 3, ONE, 3, 3, 3, ONE));
    wait_drained();
  endtask

  // Mostly true rotations with random content, the rest corners and noise
  task automatic test_random_mix(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      maybe_idle();
      pick = $urandom_range(0, 19);
      if (pick < 10)      send_matrix(rotation_matrix(1'b0));
      else if (pick < 14) send_matrix(rotation_matrix(1'b1));
      else if (pick < 17) send_matrix(corner_matrix());
      else                send_matrix(noise_matrix());
    end
  endtask

  // Hold the sender until the pipeline has emptied, then resume
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_matrix(rotation_matrix(1'b1));
    wait_drained();
    for (int i = 0; i < 10; i++) send_matrix(corner_matrix());
  endtask

  // Full rate with no idling to close the run
  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 2 == 0) send_matrix(rotation_matrix(1'b1));
      else            send_matrix(noise_matrix());
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    r00   = '0;
    r01   = '0;
    r02   = '0;
    r10   = '0;
    r11   = '0;
    r12   = '0;
    r20   = '0;
    r21   = '0;
    r22   = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_special_cases();
    test_random_mix(800);
    test_drain_pause();
    test_random_mix(700);
    test_back_to_back(300);
    wait_drained();

    $display("%0d matrices transferred, %0d quaternions checked, %0d field mismatches",
             matrices_sent, quats_checked, mismatches);
    $display("covered range corners, half and quarter turns, clamped and saturated roots,");
    $display("random rotations and noise with idle gaps, a full drain and full-rate bursts");
    if (mismatches == 0 && unexpected == 0 && pending_quats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("timeout with %0d quaternions outstanding", pending_quats.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/rmq_pkg.sv
design/rmq_sqrt_pipe.sv
design/rotation_matrix_to_quaternion_unit.sv
sim/tb_rotation_matrix_to_quaternion_unit.sv
